// ===== sv/psrc_pkg.sv =====
package psrc_pkg;

  // Command codes carried by the kind field.
  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_RAMP     = 3'd1,
    KIND_TIMED    = 3'd2,
    KIND_STOP_DIR = 3'd3,
    KIND_STOP_ALL = 3'd4,
    KIND_DRIVE    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIVA_GO,
    ST_DIVA_WAIT,
    ST_DIVB_GO,
    ST_DIVB_WAIT,
    ST_EMIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;       // latch the incoming word
    logic execute;       // apply the latched command
    logic div_start;     // launch the shared divider
    logic div_sel;       // 0: distance / step, 1: ramp time / update count
    logic latch_quot;    // keep the update count
    logic timed_finish;  // commit step and interval of a timed ramp
    logic emit;          // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_timed;
    logic dist_zero;
    logic div_done;
  } sts_t;

  // distance / 50 for distances below 256: (distance * 41) >> 11
  localparam logic [5:0]  Div50Mul    = 6'd41;
  localparam int unsigned Div50Shift  = 11;
  localparam logic [15:0] MinInterval = 16'd10;
  localparam int unsigned DivSteps    = 16;

endpackage

// ===== sv/pwm_speed_ramp_controller.sv =====
// H-bridge soft-start ramp controller: one command word in, one status word out.
// Each accepted word is captured, executed, then emitted into the result register;
// a timed ramp with a non-zero distance runs two divider passes before the emit.
// A stalled result holds the next word in the emit state. One word is in flight
// at a time.
// Reset (rst_ni low, asynchronous) clears trackers, ramp state, pin levels and valid.
module pwm_speed_ramp_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic        direction_i,
  input  logic [7:0]  target_speed_i,
  input  logic [7:0]  step_size_i,
  input  logic [15:0] interval_ms_i,
  input  logic [15:0] ramp_time_ms_i,
  input  logic [7:0]  drive_duty_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        forward_level_o,
  output logic        reverse_level_o,
  output logic [7:0]  enable_duty_o,
  output logic        ramping_o,
  output logic [7:0]  speed_cw_o,
  output logic [7:0]  speed_ccw_o
);

  // The controller sequences each word: capture, execute, optional divider
  // passes for a timed ramp, then emit into the result register.
  psrc_pkg::cmd_t cmd;
  psrc_pkg::sts_t sts;

  psrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the speed trackers, ramp parameters, bridge pins and the
  // result register; the tick update (step toward goal, clamp at goal) is done
  // in the execute state.
  psrc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .direction_i     (direction_i),
    .target_speed_i  (target_speed_i),
    .step_size_i     (step_size_i),
    .interval_ms_i   (interval_ms_i),
    .ramp_time_ms_i  (ramp_time_ms_i),
    .drive_duty_i    (drive_duty_i),
    .forward_level_o (forward_level_o),
    .reverse_level_o (reverse_level_o),
    .enable_duty_o   (enable_duty_o),
    .ramping_o       (ramping_o),
    .speed_cw_o      (speed_cw_o),
    .speed_ccw_o     (speed_ccw_o)
  );

endmodule

// ===== sv/psrc_div.sv =====
module psrc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        done_o,
  output logic [15:0] quotient_o
);

  logic [15:0] quo_q, quo_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [8:0]  shifted;
  logic        ge;

  // Restoring division, one quotient bit a cycle.
  always_comb begin
    shifted = {rem_q, quo_q[15]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? 8'(shifted - {1'b0, dvs_q}) : shifted[7:0];
    quo_d   = {quo_q[14:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(psrc_pkg::DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/psrc_dp.sv =====
module psrc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psrc_pkg::cmd_t    cmd_i,
  output psrc_pkg::sts_t    sts_o,
  input  logic [2:0]        kind_i,
  input  logic              direction_i,
  input  logic [7:0]        target_speed_i,
  input  logic [7:0]        step_size_i,
  input  logic [15:0]       interval_ms_i,
  input  logic [15:0]       ramp_time_ms_i,
  input  logic [7:0]        drive_duty_i,
  output logic              forward_level_o,
  output logic              reverse_level_o,
  output logic [7:0]        enable_duty_o,
  output logic              ramping_o,
  output logic [7:0]        speed_cw_o,
  output logic [7:0]        speed_ccw_o
);

  // Latched command word.
  logic [2:0]  kind_q;
  logic        dir_q;
  logic [7:0]  target_q;
  logic [7:0]  step_in_q;
  logic [15:0] interval_in_q;
  logic [15:0] rtime_q;
  logic [7:0]  duty_in_q;

  // Controller state.
  logic [7:0]  cw_q, ccw_q, goal_q, step_q, duty_q;
  logic [15:0] interval_q, elapsed_q;
  logic        ramp_dir_q, active_q, fwd_q, rev_q;

  // Timed ramp scratch.
  logic [7:0]  dist_q;
  logic [2:0]  st_q;
  logic [7:0]  q1_q;

  // Result register.
  logic        res_fwd_q, res_rev_q, res_ramping_q;
  logic [7:0]  res_duty_q, res_cw_q, res_ccw_q;

  logic [7:0]  cmd_cur, span, ramp_cur, next_up, next_dn, next_spd;
  logic [8:0]  sum;
  logic [13:0] prod;
  logic [2:0]  st;
  logic [15:0] elapsed_inc, iv;
  logic        due;
  logic [15:0] div_dividend, div_quot;
  logic [7:0]  div_divisor;
  logic        div_done;

  always_comb begin
    cmd_cur = dir_q ? ccw_q : cw_q;
    span    = (target_q >= cmd_cur) ? 8'(target_q - cmd_cur) : 8'(cmd_cur - target_q);
    prod    = 14'(span) * 14'(psrc_pkg::Div50Mul);
    st      = prod[13:psrc_pkg::Div50Shift];
    if (st == 3'd0) begin
      st = 3'd1;
    end

    ramp_cur = ramp_dir_q ? ccw_q : cw_q;
    sum      = {1'b0, ramp_cur} + {1'b0, step_q};
    next_up  = (sum > {1'b0, goal_q}) ? goal_q : sum[7:0];
    next_dn  = (ramp_cur < step_q || 8'(ramp_cur - step_q) < goal_q) ?
               goal_q : 8'(ramp_cur - step_q);
    next_spd = (goal_q > ramp_cur) ? next_up : next_dn;

    elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
    due         = elapsed_inc >= interval_q;

    div_dividend = cmd_i.div_sel ? rtime_q : {8'd0, dist_q};
    div_divisor  = cmd_i.div_sel ? q1_q : {5'd0, st_q};
    iv           = (div_quot < psrc_pkg::MinInterval) ? psrc_pkg::MinInterval : div_quot;
  end

  psrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign sts_o.is_timed  = (psrc_pkg::kind_e'(kind_q) == psrc_pkg::KIND_TIMED);
  assign sts_o.dist_zero = (span == 8'd0);
  assign sts_o.div_done  = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q        <= kind_i;
      dir_q         <= direction_i;
      target_q      <= target_speed_i;
      step_in_q     <= step_size_i;
      interval_in_q <= interval_ms_i;
      rtime_q       <= ramp_time_ms_i;
      duty_in_q     <= drive_duty_i;
    end
    if (cmd_i.execute) begin
      dist_q <= span;
      st_q   <= st;
    end
    if (cmd_i.latch_quot) begin
      q1_q <= div_quot[7:0];
    end
    if (cmd_i.emit) begin
      res_fwd_q     <= fwd_q;
      res_rev_q     <= rev_q;
      res_duty_q    <= duty_q;
      res_ramping_q <= active_q;
      res_cw_q      <= cw_q;
      res_ccw_q     <= ccw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q       <= '0;
      ccw_q      <= '0;
      goal_q     <= '0;
      step_q     <= '0;
      interval_q <= '0;
      elapsed_q  <= '0;
      ramp_dir_q <= 1'b0;
      active_q   <= 1'b0;
      fwd_q      <= 1'b0;
      rev_q      <= 1'b0;
      duty_q     <= '0;
    end else begin
      if (cmd_i.execute) begin
        unique case (psrc_pkg::kind_e'(kind_q))
          psrc_pkg::KIND_TICK: begin
            if (active_q) begin
              if (due) begin
                elapsed_q <= '0;
                if (ramp_cur == goal_q) begin
                  active_q <= 1'b0;
                end else begin
                  if (ramp_dir_q) begin
                    ccw_q <= next_spd;
                  end else begin
                    cw_q <= next_spd;
                  end
                  fwd_q  <= !ramp_dir_q;
                  rev_q  <= ramp_dir_q;
                  duty_q <= next_spd;
                  if (next_spd == goal_q) begin
                    active_q <= 1'b0;
                  end
                end
              end else begin
                elapsed_q <= elapsed_inc;
              end
            end
          end
          psrc_pkg::KIND_RAMP: begin
            ramp_dir_q <= dir_q;
            goal_q     <= target_q;
            step_q     <= step_in_q;
            interval_q <= interval_in_q;
            elapsed_q  <= '0;
            active_q   <= 1'b1;
          end
          psrc_pkg::KIND_TIMED: begin
            ramp_dir_q <= dir_q;
            goal_q     <= target_q;
            elapsed_q  <= '0;
            if (span == 8'd0) begin
              active_q <= 1'b0;
            end
          end
          psrc_pkg::KIND_STOP_DIR: begin
            duty_q <= '0;
            if (dir_q) begin
              ccw_q <= '0;
            end else begin
              cw_q <= '0;
            end
            active_q <= 1'b0;
          end
          psrc_pkg::KIND_STOP_ALL: begin
            duty_q   <= '0;
            cw_q     <= '0;
            ccw_q    <= '0;
            active_q <= 1'b0;
          end
          psrc_pkg::KIND_DRIVE: begin
            fwd_q  <= !dir_q;
            rev_q  <= dir_q;
            duty_q <= duty_in_q;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.timed_finish) begin
        step_q     <= {5'd0, st_q};
        interval_q <= iv;
        active_q   <= 1'b1;
      end
    end
  end

  assign forward_level_o = res_fwd_q;
  assign reverse_level_o = res_rev_q;
  assign enable_duty_o   = res_duty_q;
  assign ramping_o       = res_ramping_q;
  assign speed_cw_o      = res_cw_q;
  assign speed_ccw_o     = res_ccw_q;

endmodule

// ===== sv/psrc_ctrl.sv =====
module psrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psrc_pkg::cmd_t    cmd_o,
  input  psrc_pkg::sts_t    sts_i
);

  psrc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psrc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      psrc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = psrc_pkg::ST_EXEC;
        end
      end
      psrc_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
        if (sts_i.is_timed && !sts_i.dist_zero) begin
          state_d = psrc_pkg::ST_DIVA_GO;
        end else begin
          state_d = psrc_pkg::ST_EMIT;
        end
      end
      psrc_pkg::ST_DIVA_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = psrc_pkg::ST_DIVA_WAIT;
      end
      psrc_pkg::ST_DIVA_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_quot = 1'b1;
          state_d          = psrc_pkg::ST_DIVB_GO;
        end
      end
      psrc_pkg::ST_DIVB_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = psrc_pkg::ST_DIVB_WAIT;
      end
      psrc_pkg::ST_DIVB_WAIT: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.timed_finish = 1'b1;
          state_d            = psrc_pkg::ST_EMIT;
        end
      end
      psrc_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = psrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psrc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != psrc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/psrc_chk.sv =====
module psrc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        forward_level_o,
  input logic        reverse_level_o,
  input logic [7:0]  enable_duty_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(enable_duty_o))
    else $error("stalled result word changed");

  // Stall the input once a word has been taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // A result only appears while a word is in flight.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a word in flight");

  // Never drive both bridge legs, never drive duty without a direction.
  a_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(forward_level_o && reverse_level_o) &&
      (enable_duty_o == 8'd0 || forward_level_o || reverse_level_o))
    else $error("illegal bridge levels");

endmodule

bind pwm_speed_ramp_controller psrc_chk u_psrc_chk (.*);
